/* sv/srgbr_pkg.sv */
package srgbr_pkg;

  localparam int MemDepth  = 65536;
  localparam int AddrBits  = 16;
  localparam int SumBits   = 32;
  localparam int SampBits  = 16;
  localparam int DivBits   = 16;
  localparam int QBits     = 12;
  localparam int TabSize   = 1 << QBits;
  localparam int LaneStages = QBits + 2;

  // Denominator of the linear segment: 10 * 2^QBits.
  localparam longint LinDen = longint'(10) << QBits;

  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_SAMPLE_COUNT = 1'b1;

  typedef logic [SumBits-1:0] sum_t;
  typedef logic [319:0] big_t;
  typedef logic [TabSize-1:0][7:0] tab_t;

  // (1000k + 14025)^12 * 2^(5*QBits): threshold for code k on the power segment.
  function automatic big_t code_thr(int k);
    big_t r;
    r = big_t'(1);
    for (int j = 0; j < 12; j++) r = r * big_t'(1000 * k + 14025);
    r = r << (5 * QBits);
    return r;
  endfunction

  function automatic tab_t build_tab();
    tab_t t;
    big_t c12;
    big_t lhs;
    int k;
    int q;
    longint lin;
    c12 = big_t'(1);
    for (int j = 0; j < 12; j++) c12 = c12 * big_t'(269025);
    k = 0;
    for (int i = 0; i < TabSize; i++) begin
      if (longint'(i) * 64'd10000000 < (longint'(31308) << QBits)) begin
        // The linear segment covers only a few entries, so repeated
        // subtraction gives the quotient.
        lin = longint'(i) * 64'd32946;
        q = 0;
        while (lin >= LinDen) begin
          lin = lin - LinDen;
          q++;
        end
        t[i] = 8'(q);
      end else begin
        lhs = c12;
        for (int j = 0; j < 5; j++) lhs = lhs * big_t'(i);
        while (k < 255 && lhs >= code_thr(k + 1)) k++;
        t[i] = 8'(k);
      end
    end
    return t;
  endfunction

  localparam tab_t SrgbTab = build_tab();

endpackage

/* sv/srgbr_lane.sv */
module srgbr_lane (
  input  logic                              clk,
  input  logic                              en,
  input  logic [srgbr_pkg::SumBits-1:0]     sum_in,
  input  logic [srgbr_pkg::DivBits-1:0]     div_in,
  output logic [7:0]                        code
);

  // One quotient bit per stage, MSB first. Means of 1.0 or more saturate.
  logic [srgbr_pkg::SumBits-1:0] rem_r [0:srgbr_pkg::QBits];
  logic [srgbr_pkg::QBits-1:0]   q_r   [0:srgbr_pkg::QBits];
  logic [srgbr_pkg::DivBits-1:0] dv_r  [0:srgbr_pkg::QBits];
  logic                          ovf_r [0:srgbr_pkg::QBits];
  logic [7:0]                    code_r;

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= sum_in;
      q_r[0]   <= '0;
      dv_r[0]  <= div_in;
      ovf_r[0] <= sum_in >= (srgbr_pkg::SumBits'(div_in) << srgbr_pkg::QBits);
    end
  end

  for (genvar k = 1; k <= srgbr_pkg::QBits; k++) begin : g_stage
    localparam int B = srgbr_pkg::QBits - k;
    logic [srgbr_pkg::SumBits-1:0] shd;
    logic                          take;
    assign shd  = srgbr_pkg::SumBits'(dv_r[k-1]) << B;
    assign take = rem_r[k-1] >= shd;
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= take ? rem_r[k-1] - shd : rem_r[k-1];
        q_r[k]   <= q_r[k-1] | (take ? srgbr_pkg::QBits'(1) << B : '0);
        dv_r[k]  <= dv_r[k-1];
        ovf_r[k] <= ovf_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      code_r <= ovf_r[srgbr_pkg::QBits] ? 8'hFF :
                srgbr_pkg::SrgbTab[q_r[srgbr_pkg::QBits]];
    end
  end

  assign code = code_r;

endmodule

/* sv/sample_accumulate_srgb_resolve.sv */
// Progressive render resolve. Each input transfer carries a pixel position and one
// RGB radiance sample (unsigned Q4.12). The pixel's three 32-bit saturating sums are
// read from one synchronous memory, updated and written back; a pass with
// sample_count of one clears the sums before the add. Each sum is divided by
// sample_count, clamped to 1.0 and sRGB-encoded to 8 bits by a table lookup.
// Both channels use valid/ready. One item can be accepted every cycle while in_ready
// is high. When nothing stalls, a result passes from its input transfer through the
// memory read, the update stage, twelve one-bit divide stages, the table read and
// the output register. A write of an entry in the same cycle as a read of it is
// forwarded, so the same pixel may come back to back. When the receiver stalls the
// result holds in the output register and the pipeline keeps taking items until
// its last stage is full, then in_ready drops.
// Reset clears all valid flags and sets frame_width to 256 and sample_count to 1.
// The sum memory is not cleared: a pixel must first be seen with sample_count of one.
// Configuration uses an APB-style port: frame_width at 0x0, sample_count at 0x4.
module sample_accumulate_srgb_resolve (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_pixel_row,
  input  logic [7:0]  in_pixel_col,
  input  logic [15:0] in_sample_red,
  input  logic [15:0] in_sample_green,
  input  logic [15:0] in_sample_blue,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_out_row,
  output logic [7:0]  out_out_col,
  output logic [7:0]  out_srgb_red,
  output logic [7:0]  out_srgb_green,
  output logic [7:0]  out_srgb_blue,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int NS = srgbr_pkg::LaneStages;
  localparam int W3 = 3 * srgbr_pkg::SumBits;

  logic [8:0]  frame_width_r;
  logic [15:0] sample_count_r;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= 9'd256;
      sample_count_r <= 16'd1;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        srgbr_pkg::REG_FRAME_WIDTH:  frame_width_r  <= pwdata[8:0];
        srgbr_pkg::REG_SAMPLE_COUNT: sample_count_r <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      srgbr_pkg::REG_FRAME_WIDTH:  prdata = {23'd0, frame_width_r};
      srgbr_pkg::REG_SAMPLE_COUNT: prdata = {16'd0, sample_count_r};
      default:                     prdata = '0;
    endcase
  end

  // The whole pipeline advances together unless the last lane stage and the
  // output register are both full and the receiver is not taking.
  logic en;
  logic [NS-1:0] pv_r;
  logic out_valid_r;
  logic out_valid_nxt;

  assign en       = !(pv_r[NS-1] && out_valid_r && !out_ready);
  assign in_ready = en;

  // Address wraps to the memory depth.
  logic [16:0] row_mul;
  logic [srgbr_pkg::AddrBits-1:0] rd_addr;
  assign row_mul = 17'(in_pixel_row) * 17'(frame_width_r);
  assign rd_addr = row_mul[15:0] + {8'd0, in_pixel_col};

  logic [W3-1:0] mem [srgbr_pkg::MemDepth];
  logic [W3-1:0] rd_r;

  // Update stage.
  logic                           s1_v_r;
  logic [srgbr_pkg::AddrBits-1:0] s1_addr_r;
  logic [15:0]                    s1_rc_r;
  logic [47:0]                    s1_samp_r;
  logic                           s1_clr_r;

  logic                           lw_v_r;
  logic [srgbr_pkg::AddrBits-1:0] lw_addr_r;
  logic [W3-1:0]                  lw_data_r;

  logic [W3-1:0] old_sum;
  logic [W3-1:0] new_sum;

  assign old_sum = (lw_v_r && lw_addr_r == s1_addr_r) ? lw_data_r : rd_r;

  for (genvar c = 0; c < 3; c++) begin : g_add
    logic [32:0] s;
    logic [31:0] base;
    assign base = s1_clr_r ? 32'd0 : old_sum[c*32 +: 32];
    assign s    = {1'b0, base} + {17'd0, s1_samp_r[c*16 +: 16]};
    assign new_sum[c*32 +: 32] = s[32] ? 32'hFFFF_FFFF : s[31:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rd_r      <= mem[rd_addr];
      s1_addr_r <= rd_addr;
      s1_rc_r   <= {in_pixel_row, in_pixel_col};
      s1_samp_r <= {in_sample_blue, in_sample_green, in_sample_red};
      s1_clr_r  <= sample_count_r == 16'd1;
      lw_addr_r <= s1_addr_r;
      lw_data_r <= new_sum;
      if (s1_v_r) mem[s1_addr_r] <= new_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      lw_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_valid;
      lw_v_r <= s1_v_r;
    end
  end

  // A sample count of zero divides by one.
  logic [15:0] divisor;
  assign divisor = (sample_count_r == 16'd0) ? 16'd1 : sample_count_r;

  logic [7:0] code [3];
  for (genvar c = 0; c < 3; c++) begin : g_lane
    srgbr_lane u_lane (
      .clk    (clk),
      .en     (en),
      .sum_in (new_sum[c*32 +: 32]),
      .div_in (divisor),
      .code   (code[c])
    );
  end

  // Position travels beside the lanes.
  logic [15:0] rc_r [NS];
  always_ff @(posedge clk) begin
    if (en) begin
      rc_r[0] <= s1_rc_r;
      for (int k = 1; k < NS; k++) rc_r[k] <= rc_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= '0;
    end else if (en) begin
      pv_r <= {pv_r[NS-2:0], s1_v_r};
    end
  end

  logic [15:0] out_rc_r;
  logic [23:0] out_rgb_r;

  always_comb begin
    if (en && pv_r[NS-1]) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en && pv_r[NS-1]) begin
      out_rc_r  <= rc_r[NS-1];
      out_rgb_r <= {code[2], code[1], code[0]};
    end
  end

  assign out_valid      = out_valid_r;
  assign out_out_row    = out_rc_r[15:8];
  assign out_out_col    = out_rc_r[7:0];
  assign out_srgb_red   = out_rgb_r[7:0];
  assign out_srgb_green = out_rgb_r[15:8];
  assign out_srgb_blue  = out_rgb_r[23:16];

endmodule
